// ----- src/mapd_pkg.sv -----
package mapd_pkg;

    localparam int LEN_W      = 7;
    localparam int THR_W      = 16;
    localparam int CH_PORT_W  = 5;
    localparam int SMP_PORT_W = 16;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic REG_WINDOW    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [LEN_W-1:0] WINDOW_RESET    = 7'd8;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'hFFFF;

    typedef struct packed {
        logic capture;
        logic load;
        logic hist;
        logic update;
        logic div_step;
        logic load_out;
    } mapd_cmd_t;

    typedef struct packed {
        logic in_range;
        logic result_due;
        logic out_free;
    } mapd_sts_t;

endpackage

// ----- src/mapd_ctrl.sv -----
module mapd_ctrl
    import mapd_pkg::*;
#(
    parameter int SUM_W = 23
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  mapd_sts_t sts,
    output mapd_cmd_t cmd
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_HIST   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = sample_valid;
                if (sample_valid && sts.in_range)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_HIST;
            end
            S_HIST:
            begin
                cmd.hist   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = sts.result_due ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.load_out = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != S_IDLE);

endmodule

// ----- src/mapd_datapath.sv -----
module mapd_datapath
    import mapd_pkg::*;
#(
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_WINDOW   = 64,
    parameter int SMP_W        = 16,
    parameter int SUM_W        = 23
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CH_PORT_W-1:0]  channel,
    input  logic [SMP_PORT_W-1:0] sample,
    input  mapd_cmd_t             cmd,
    output mapd_sts_t             sts,
    input  logic [LEN_W-1:0]      win_len,
    input  logic [THR_W-1:0]      threshold,
    input  logic                  restart,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CH_PORT_W-1:0]  out_channel,
    output logic [SMP_PORT_W-1:0] average,
    output logic                  warning
);

    localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = NUM_CHANNELS * MAX_WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = ((PW > LEN_W) ? PW : LEN_W) + 1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] fill;
        logic [PW-1:0]    pos;
    } chan_t;

    chan_t             chan_mem [NUM_CHANNELS];
    chan_t             chan_rd_reg;
    logic [NUM_CHANNELS-1:0] chan_vld_reg;
    logic [SMP_W-1:0]  hist_mem [DEPTH];
    logic [SMP_W-1:0]  hist_rd_reg;

    logic [CW-1:0]     ch_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic [AW-1:0]     slot_reg;
    logic [PW-1:0]     pos_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;

    logic                  out_valid_reg;
    logic [CH_PORT_W-1:0]  out_channel_reg;
    logic [SMP_PORT_W-1:0] average_reg;
    logic                  warning_reg;

    chan_t             cur;
    logic [PW-1:0]     pos_fix;
    logic [AW-1:0]     hist_addr;
    logic              full_before;
    logic [SUM_W-1:0]  sum_upd;
    logic [LEN_W-1:0]  fill_upd;
    logic [CMP_W-1:0]  pos_inc;
    logic [PW-1:0]     pos_upd;
    chan_t             chan_next;
    logic [LEN_W:0]    trial;
    logic              trial_ge;
    logic [SMP_PORT_W-1:0] mean;

    // lookup stage
    always_comb
    begin
        cur       = chan_vld_reg[ch_reg] ? chan_rd_reg : '0;
        pos_fix   = (CMP_W'(cur.pos) >= CMP_W'(win_len)) ? '0 : cur.pos;
        hist_addr = AW'(ch_reg) * AW'(MAX_WINDOW) + AW'(pos_fix);
    end

    // update stage
    always_comb
    begin
        full_before = (fill_reg >= win_len);
        if (full_before)
        begin
            sum_upd  = sum_reg - SUM_W'(hist_rd_reg) + SUM_W'(smp_reg);
            fill_upd = fill_reg;
        end
        else
        begin
            sum_upd  = sum_reg + SUM_W'(smp_reg);
            fill_upd = LEN_W'(fill_reg + 1'b1);
        end
        pos_inc   = CMP_W'(pos_reg) + CMP_W'(1);
        pos_upd   = (pos_inc >= CMP_W'(win_len)) ? '0 : PW'(pos_inc);
        chan_next = '{sum: sum_upd, fill: fill_upd, pos: pos_upd};
    end

    // restoring divider step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, win_len});
        mean     = SMP_PORT_W'(quo_reg[SMP_W-1:0]);
    end

    always_comb
    begin
        sts.in_range   = (int'(channel) < NUM_CHANNELS);
        sts.result_due = (fill_upd >= win_len);
        sts.out_free   = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chan_rd_reg <= chan_mem[ch_reg];
        end
        if (cmd.update)
        begin
            chan_mem[ch_reg] <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist)
        begin
            hist_rd_reg <= hist_mem[hist_addr];
        end
        if (cmd.update)
        begin
            hist_mem[slot_reg] <= smp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_vld_reg <= '0;
        end
        else if (restart)
        begin
            chan_vld_reg <= '0;
        end
        else if (cmd.update)
        begin
            chan_vld_reg[ch_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg  <= CW'(channel);
            smp_reg <= sample[SMP_W-1:0];
        end
        if (cmd.hist)
        begin
            pos_reg  <= pos_fix;
            fill_reg <= cur.fill;
            sum_reg  <= cur.sum;
            slot_reg <= hist_addr;
        end
        if (cmd.update)
        begin
            quo_reg <= sum_upd;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? LEN_W'(trial - {1'b0, win_len}) : trial[LEN_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_channel_reg <= CH_PORT_W'(ch_reg);
            average_reg     <= mean;
            warning_reg     <= (mean > threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign average      = average_reg;
    assign warning      = warning_reg;

endmodule

// ----- src/multichannel_moving_average_peak_detect.sv -----
// Flow: a sample is captured in S_IDLE and passes S_LOAD, S_HIST and S_UPDATE; a sample
// for a channel out of range is dropped in S_IDLE. When a result is due, S_DIVIDE runs
// the bit-serial divider (one quotient bit per cycle) and S_FINISH loads the output
// register. No new sample is taken until the control is back in S_IDLE; a result held
// by result_stall holds the next one in S_FINISH, which stalls the input.
// Reset: window_length 8, threshold 65535, every channel empty; a write to
// window_length empties every channel again at once.
module multichannel_moving_average_peak_detect
    import mapd_pkg::*;
#(
    parameter int NUM_CHANNELS = 32,
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  logic [CH_PORT_W-1:0]  channel,
    input  logic [SMP_PORT_W-1:0] sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CH_PORT_W-1:0]  out_channel,
    output logic [SMP_PORT_W-1:0] average,
    output logic                  warning
);

    localparam int SMP_W   = (SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W;
    localparam int SUM_W   = SMP_W + LEN_W;
    localparam int WIN_CAP = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;

    logic [LEN_W-1:0] window_reg;
    logic [THR_W-1:0] threshold_reg;
    logic [LEN_W-1:0] win_len;
    logic             cfg_we;
    logic             restart;
    mapd_cmd_t        cmd;
    mapd_sts_t        sts;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign restart = cfg_we && (paddr[2] == REG_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_WINDOW:    window_reg    <= pwdata[LEN_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW:    prdata = DATA_W'(window_reg);
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (window_reg == '0)
        begin
            win_len = LEN_W'(1);
        end
        else if (window_reg > LEN_W'(WIN_CAP))
        begin
            win_len = LEN_W'(WIN_CAP);
        end
        else
        begin
            win_len = window_reg;
        end
    end

    mapd_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    mapd_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SMP_W        (SMP_W),
        .SUM_W        (SUM_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .channel      (channel),
        .sample       (sample),
        .cmd          (cmd),
        .sts          (sts),
        .win_len      (win_len),
        .threshold    (threshold_reg),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_channel  (out_channel),
        .average      (average),
        .warning      (warning)
    );

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid || !result_stall))
        else $error("output register overwritten");

    // a transfer in is only taken while no item is in flight
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |-> (!cmd.update && !cmd.div_step && !cmd.load_out))
        else $error("sample taken while busy");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.load_out))
        else $error("result valid without a load");

endmodule
